// ===== src/pfc_pkg.sv =====
// Shared constants and types for the Playfair digraph cipher.
package pfc_pkg;

  localparam int GRID_SIDE_DEF = 5;
  localparam int ALPHA         = 26;
  localparam int LET_W         = 5;
  localparam int CMD_W         = 3;

  localparam logic [LET_W-1:0] LET_I = 5'd8;
  localparam logic [LET_W-1:0] LET_J = 5'd9;
  localparam logic [LET_W-1:0] LET_X = 5'd23;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_KEY    = 3'd1,
    CMD_FINISH = 3'd2,
    CMD_PLAIN  = 3'd3,
    CMD_CIPHER = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_EMIT = 4'b0100,
    ST_FILL = 4'b1000
  } st_t;

endpackage

// ===== src/pfc_xform.sv =====
// Same-row, same-column and rectangle rules on a pair of square cells.
module pfc_xform
  import pfc_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  parameter int CELL_W    = $clog2(GRID_SIDE * GRID_SIDE)
) (
  input  logic [CELL_W-1:0] pa,
  input  logic [CELL_W-1:0] pb,
  input  logic              dec,
  output logic [CELL_W-1:0] qa,
  output logic [CELL_W-1:0] qb
);

  localparam int ROW_W = $clog2(GRID_SIDE);
  localparam logic [ROW_W-1:0] LAST = ROW_W'(GRID_SIDE - 1);

  function automatic logic [ROW_W-1:0] row_of(input logic [CELL_W-1:0] p);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int k = 1; k < GRID_SIDE; k++) begin
      if (p >= CELL_W'(k * GRID_SIDE)) begin
        r = ROW_W'(k);
      end
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] bump(input logic [ROW_W-1:0] v, input logic d);
    logic [ROW_W-1:0] w;
    if (d) begin
      w = (v == '0) ? LAST : v - ROW_W'(1);
    end else begin
      w = (v == LAST) ? '0 : v + ROW_W'(1);
    end
    return w;
  endfunction

  logic [ROW_W-1:0] r1, c1, r2, c2;
  logic [ROW_W-1:0] r1n, c1n, r2n, c2n;

  always_comb begin
    r1 = row_of(pa);
    r2 = row_of(pb);
    c1 = ROW_W'(pa - CELL_W'(r1 * GRID_SIDE));
    c2 = ROW_W'(pb - CELL_W'(r2 * GRID_SIDE));
    r1n = r1;
    r2n = r2;
    c1n = c1;
    c2n = c2;
    if (r1 == r2) begin
      c1n = bump(c1, dec);
      c2n = bump(c2, dec);
    end else if (c1 == c2) begin
      r1n = bump(r1, dec);
      r2n = bump(r2, dec);
    end else begin
      c1n = c2;
      c2n = c1;
    end
    qa = CELL_W'(r1n * GRID_SIDE) + CELL_W'(c1n);
    qb = CELL_W'(r2n * GRID_SIDE) + CELL_W'(c2n);
  end

endmodule

// ===== src/playfair_digraph_cipher.sv =====
// Top level of the Playfair digraph cipher with a streamed key square.
//
//   Channel | Direction | tdata             | tuser   | tlast
//   in_     | slave     | letter [4:0]      | cmd     | message_end
//   out_    | master    | out_letter [4:0]  | (none)  | run_end
//
// A key letter or clear command is handled on acceptance; a finish command walks the
// alphabet, one letter per cycle, placing each letter not yet in the square while it has room.
// A plaintext or cipher letter that completes a pair is looked up in two reads
// (letter-to-cell memory read, then square memory read), then the result slots
// are emitted one per cycle while the output is not stalled.
// Reset clears the letter-seen flags, the fill count and the pending letter.
// A stall on the output holds the sequencer; no new transaction is taken
// until all results of the current one are in the output register.
module playfair_digraph_cipher
  import pfc_pkg::*;
#(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] letter, [7:5] zero
  input  logic [2:0] in_tuser,   // [2:0] cmd
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] out_letter, [7:5] zero
  output logic       out_tlast
);

  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int FILL_W = $clog2(CELLS + 1);

  st_t state_r, state_nxt;
  logic [ALPHA-1:0] seen_r, seen_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [LET_W-1:0] held_letter_r, held_letter_nxt;
  logic held_valid_r, held_valid_nxt;
  logic [LET_W-1:0] walk_r, walk_nxt;
  logic ha_r, ha_nxt, hb_r, hb_nxt;
  logic dec_r, dec_nxt, rep2_r, rep2_nxt;
  logic [1:0] k_r, k_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [LET_W-1:0] out_letter_r, out_letter_nxt;
  logic out_last_r, out_last_nxt;

  logic [CELL_W-1:0] place_mem [ALPHA];
  logic [LET_W-1:0]  sq_mem [CELLS];
  logic [CELL_W-1:0] place_rd_a_r, place_rd_b_r;
  logic [LET_W-1:0]  sq_rd_a_r, sq_rd_b_r;

  logic in_fire, let_ok, in_end;
  logic [LET_W-1:0] in_let;
  logic pl_req, pl_ok, pl_en, pl_ij;
  logic [LET_W-1:0] pl_letter;
  logic rd_en, sq_rd_en, start;
  logic [LET_W-1:0] xa, xb;
  logic [LET_W:0] res_a, res_b;
  logic [CELL_W-1:0] pa, pb, qa, qb;
  logic out_free, present, last_step, is_last;
  logic [LET_W-1:0] cur_letter;

  function automatic logic [LET_W:0] resolve(input logic [LET_W-1:0] v,
                                             input logic [ALPHA-1:0] seen);
    logic [LET_W-1:0] a;
    logic h;
    if (v == LET_I || v == LET_J) begin
      a = seen[LET_I] ? LET_I : LET_J;
      h = seen[LET_I] | seen[LET_J];
    end else begin
      a = v;
      h = seen[v];
    end
    return {h, a};
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign in_let     = in_tdata[LET_W-1:0];
  assign in_end     = in_tlast;
  assign let_ok     = (in_let < LET_W'(ALPHA));
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_letter_r};
  assign out_tlast  = out_last_r;
  assign out_free   = ~out_tvalid_r | out_tready;

  assign pl_letter = (state_r == ST_FILL) ? walk_r : in_let;
  assign pl_ij     = (pl_letter == LET_I) || (pl_letter == LET_J);
  assign pl_ok     = (fill_r < FILL_W'(CELLS)) &&
                     (pl_ij ? !(seen_r[LET_I] | seen_r[LET_J]) : !seen_r[pl_letter]);
  assign pl_en     = pl_req & pl_ok;

  assign res_a = resolve(xa, seen_r);
  assign res_b = resolve(xb, seen_r);

  assign pa = ha_r ? place_rd_a_r : '0;
  assign pb = hb_r ? place_rd_b_r : '0;

  pfc_xform #(
    .GRID_SIDE(GRID_SIDE),
    .CELL_W   (CELL_W)
  ) u_xform (
    .pa (pa),
    .pb (pb),
    .dec(dec_r),
    .qa (qa),
    .qb (qb)
  );

  assign cur_letter = k_r[0] ? sq_rd_b_r : sq_rd_a_r;
  assign present    = ~dec_r | (cur_letter != LET_X);
  assign last_step  = dec_r ? (k_r == 2'd1) : (k_r == (rep2_r ? 2'd3 : 2'd1));
  assign is_last    = dec_r ? (k_r[0] | (sq_rd_b_r == LET_X)) : last_step;

  always_comb begin
    state_nxt       = state_r;
    seen_nxt        = seen_r;
    fill_nxt        = fill_r;
    held_letter_nxt = held_letter_r;
    held_valid_nxt  = held_valid_r;
    walk_nxt        = walk_r;
    ha_nxt          = ha_r;
    hb_nxt          = hb_r;
    dec_nxt         = dec_r;
    rep2_nxt        = rep2_r;
    k_nxt           = k_r;
    out_tvalid_nxt  = out_tvalid_r & ~out_tready;
    out_letter_nxt  = out_letter_r;
    out_last_nxt    = out_last_r;
    pl_req          = 1'b0;
    sq_rd_en        = 1'b0;
    start           = 1'b0;
    xa              = in_let;
    xb              = LET_X;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_tuser)
            CMD_CLEAR: begin
              seen_nxt       = '0;
              fill_nxt       = '0;
              held_valid_nxt = 1'b0;
            end
            CMD_KEY: begin
              pl_req = let_ok;
            end
            CMD_FINISH: begin
              walk_nxt  = '0;
              state_nxt = ST_FILL;
            end
            CMD_PLAIN: begin
              if (let_ok) begin
                dec_nxt  = 1'b0;
                rep2_nxt = 1'b0;
                if (held_valid_r) begin
                  xa    = held_letter_r;
                  start = 1'b1;
                  if (held_letter_r == in_let) begin
                    xb             = LET_X;
                    rep2_nxt       = in_end;
                    held_valid_nxt = ~in_end;
                  end else begin
                    xb             = in_let;
                    held_valid_nxt = 1'b0;
                  end
                end else if (in_end) begin
                  xa    = in_let;
                  xb    = LET_X;
                  start = 1'b1;
                end else begin
                  held_letter_nxt = in_let;
                  held_valid_nxt  = 1'b1;
                end
              end
            end
            CMD_CIPHER: begin
              if (let_ok) begin
                dec_nxt  = 1'b1;
                rep2_nxt = 1'b0;
                if (held_valid_r) begin
                  xa             = held_letter_r;
                  xb             = in_let;
                  start          = 1'b1;
                  held_valid_nxt = 1'b0;
                end else if (!in_end) begin
                  held_letter_nxt = in_let;
                  held_valid_nxt  = 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
          if (start) begin
            ha_nxt    = res_a[LET_W];
            hb_nxt    = res_b[LET_W];
            k_nxt     = '0;
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        sq_rd_en  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!present || out_free) begin
          if (present) begin
            out_tvalid_nxt = 1'b1;
            out_letter_nxt = cur_letter;
            out_last_nxt   = is_last;
          end
          if (last_step) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end
      ST_FILL: begin
        pl_req   = 1'b1;
        walk_nxt = walk_r + LET_W'(1);
        if (walk_r == LET_W'(ALPHA - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (pl_en) begin
      seen_nxt[pl_letter] = 1'b1;
      fill_nxt            = fill_r + FILL_W'(1);
    end
  end

  assign rd_en = start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      seen_r        <= '0;
      fill_r        <= '0;
      held_letter_r <= '0;
      held_valid_r  <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      seen_r        <= seen_nxt;
      fill_r        <= fill_nxt;
      held_letter_r <= held_letter_nxt;
      held_valid_r  <= held_valid_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r       <= walk_nxt;
    ha_r         <= ha_nxt;
    hb_r         <= hb_nxt;
    dec_r        <= dec_nxt;
    rep2_r       <= rep2_nxt;
    k_r          <= k_nxt;
    out_letter_r <= out_letter_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (pl_en) begin
      place_mem[pl_letter] <= fill_r[CELL_W-1:0];
    end
    if (rd_en) begin
      place_rd_a_r <= place_mem[res_a[LET_W-1:0]];
      place_rd_b_r <= place_mem[res_b[LET_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pl_en) begin
      sq_mem[fill_r[CELL_W-1:0]] <= pl_letter;
    end
    if (sq_rd_en) begin
      sq_rd_a_r <= sq_mem[qa];
      sq_rd_b_r <= sq_mem[qb];
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the Playfair digraph cipher with a streamed key square.
`timescale 1ns / 1ps

module testbench;
  import pfc_pkg::*;

  localparam int SIDE       = GRID_SIDE_DEF;
  localparam int CELLS      = SIDE * SIDE;
  localparam int ITEM_GOAL  = 310;
  localparam int STALL_MAX  = 4000;
  localparam int DRAIN_WAIT = 40;

  typedef struct packed {
    logic [2:0] cmd;
    logic [4:0] letter;
    logic       msg_end;
    logic       drain;
  } stim_t;

  typedef struct packed {
    logic [4:0] letter;
    logic       run_end;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  stim_t   stim_q [$];
  result_t letters_due [$];
  bit      drain_next;
  int      queued, phases, sent_count, items_taken, results_seen, errors, idle_cycles;
  logic    in_taken = 1'b0;
  wire     steady = sent_count >= 150 && sent_count < 230;

  // Shadow copy of the key square and the pairing state.
  logic [4:0] grid [CELLS];
  logic [4:0] where_is [ALPHA];
  bit         has_cell [ALPHA];
  int         filled;
  logic [4:0] pend_letter;
  bit         pend_valid;

  playfair_digraph_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit is_ij(logic [4:0] l);
    return l == LET_I || l == LET_J;
  endfunction

  function automatic void claim_cell(logic [4:0] l);
    if (filled >= CELLS) return;
    if (is_ij(l) ? (has_cell[LET_I] || has_cell[LET_J]) : has_cell[l]) return;
    has_cell[l] = 1'b1;
    where_is[l] = 5'(filled);
    grid[filled] = l;
    filled++;
  endfunction

  function automatic int cell_index(logic [4:0] l);
    if (is_ij(l)) begin
      if (has_cell[LET_I]) return int'(where_is[LET_I]);
      if (has_cell[LET_J]) return int'(where_is[LET_J]);
      return 0;
    end
    return has_cell[l] ? int'(where_is[l]) : 0;
  endfunction

  // Shift 1 enciphers a pair, shift SIDE-1 deciphers it.
  function automatic void digraph(input logic [4:0] a, input logic [4:0] b, input int shift,
                                  output logic [4:0] ra, output logic [4:0] rb);
    int p1, p2, r1, c1, r2, c2, t;
    p1 = cell_index(a);
    p2 = cell_index(b);
    r1 = p1 / SIDE;
    c1 = p1 % SIDE;
    r2 = p2 / SIDE;
    c2 = p2 % SIDE;
    if (r1 == r2) begin
      c1 = (c1 + shift) % SIDE;
      c2 = (c2 + shift) % SIDE;
    end else if (c1 == c2) begin
      r1 = (r1 + shift) % SIDE;
      r2 = (r2 + shift) % SIDE;
    end else begin
      t = c1;
      c1 = c2;
      c2 = t;
    end
    ra = grid[r1 * SIDE + c1];
    rb = grid[r2 * SIDE + c2];
  endfunction

  function automatic void playfair_step(stim_t s);
    logic [4:0] got [$];
    logic [4:0] x, y;
    result_t    r;
    if (s.cmd == CMD_CLEAR) begin
      foreach (has_cell[k]) has_cell[k] = 1'b0;
      filled = 0;
      pend_valid = 1'b0;
      return;
    end
    if (s.cmd == CMD_FINISH) begin
      for (int c = 0; c < ALPHA; c++) claim_cell(5'(c));
      return;
    end
    if (s.cmd > CMD_CIPHER || s.letter >= ALPHA) return;
    if (s.cmd == CMD_KEY) begin
      claim_cell(s.letter);
      return;
    end
    if (s.cmd == CMD_PLAIN) begin
      if (pend_valid && pend_letter == s.letter) begin
        digraph(pend_letter, LET_X, 1, x, y);
        got.push_back(x);
        got.push_back(y);
        if (s.msg_end) begin
          digraph(s.letter, LET_X, 1, x, y);
          got.push_back(x);
          got.push_back(y);
          pend_valid = 1'b0;
        end
      end else if (pend_valid) begin
        digraph(pend_letter, s.letter, 1, x, y);
        got.push_back(x);
        got.push_back(y);
        pend_valid = 1'b0;
      end else if (s.msg_end) begin
        digraph(s.letter, LET_X, 1, x, y);
        got.push_back(x);
        got.push_back(y);
      end else begin
        pend_letter = s.letter;
        pend_valid = 1'b1;
      end
    end else if (pend_valid) begin
      digraph(pend_letter, s.letter, SIDE - 1, x, y);
      if (x != LET_X) got.push_back(x);
      if (y != LET_X) got.push_back(y);
      pend_valid = 1'b0;
    end else if (!s.msg_end) begin
      pend_letter = s.letter;
      pend_valid = 1'b1;
    end
    foreach (got[k]) begin
      r.letter = got[k];
      r.run_end = k == got.size() - 1;
      letters_due.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string what, int seen, int wanted);
    $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, seen, wanted);
    errors++;
  endtask

  task automatic queue_item(logic [2:0] cmd, logic [4:0] letter, logic msg_end);
    stim_t s;
    s.cmd = cmd;
    s.letter = letter;
    s.msg_end = msg_end;
    s.drain = drain_next;
    drain_next = 1'b0;
    stim_q.push_back(s);
    queued++;
  endtask

  function automatic logic [4:0] pick_letter();
    case ($urandom_range(9))
      0: return LET_I;
      1: return LET_J;
      2: return LET_X;
      default: return 5'($urandom_range(ALPHA - 1));
    endcase
  endfunction

  task automatic queue_noise();
    case ($urandom_range(3))
      0: queue_item(3'($urandom_range(7, 5)), 5'($urandom), 1'($urandom));
      1: queue_item(3'($urandom_range(CMD_CIPHER, CMD_KEY)), 5'($urandom_range(31, ALPHA)),
                    1'($urandom));
      2: queue_item(CMD_KEY, pick_letter(), 1'($urandom));
      default: queue_item(3'($urandom_range(CMD_CIPHER, CMD_PLAIN)), pick_letter(),
                          1'($urandom));
    endcase
  endtask

  // One key set up, then a few plaintext or ciphertext messages with noise mixed in.
  task automatic queue_phase();
    int         len;
    logic [2:0] kind;
    logic [4:0] prev, l;
    phases++;
    drain_next = phases % 6 == 1;
    if ($urandom_range(9) < 8) queue_item(CMD_CLEAR, 5'($urandom), 1'($urandom));
    repeat ($urandom_range(12)) queue_item(CMD_KEY, pick_letter(), 1'($urandom));
    if ($urandom_range(9) < 8) queue_item(CMD_FINISH, 5'($urandom), 1'($urandom));
    repeat ($urandom_range(3, 1)) begin
      kind = $urandom_range(1) ? CMD_PLAIN : CMD_CIPHER;
      len = $urandom_range(9) == 0 ? 1 : $urandom_range(12, 2);
      prev = pick_letter();
      for (int n = 0; n < len; n++) begin
        l = $urandom_range(9) < 3 ? prev : pick_letter();
        if ($urandom_range(99) < 8) queue_noise();
        queue_item(kind, l, n == len - 1 || $urandom_range(99) < 4);
        prev = l;
      end
    end
  endtask

  initial begin
    foreach (has_cell[k]) has_cell[k] = 1'b0;
    filled = 0;
    pend_valid = 1'b0;
    pend_letter = '0;

    queue_item(CMD_PLAIN, 5'd31, 1'b1);
    queue_item(3'd7, 5'd5, 1'b0);
    queue_item(CMD_KEY, LET_J, 1'b0);
    queue_item(CMD_KEY, 5'd25, 1'b0);
    queue_item(CMD_KEY, 5'd0, 1'b0);
    queue_item(CMD_KEY, LET_J, 1'b0);
    queue_item(CMD_KEY, LET_I, 1'b0);
    queue_item(CMD_FINISH, 5'd0, 1'b0);
    queue_item(CMD_KEY, 5'd1, 1'b0);
    queue_item(CMD_FINISH, 5'd31, 1'b1);
    queue_item(CMD_PLAIN, 5'd0, 1'b0);
    queue_item(CMD_PLAIN, 5'd0, 1'b0);
    queue_item(CMD_PLAIN, 5'd25, 1'b0);
    queue_item(CMD_PLAIN, LET_I, 1'b1);
    queue_item(CMD_PLAIN, LET_J, 1'b0);
    queue_item(CMD_PLAIN, LET_J, 1'b1);
    queue_item(CMD_CIPHER, 5'd24, 1'b0);
    queue_item(CMD_CIPHER, 5'd24, 1'b0);
    queue_item(CMD_CIPHER, 5'd24, 1'b0);
    queue_item(CMD_CIPHER, 5'd20, 1'b0);
    queue_item(CMD_CIPHER, 5'd13, 1'b1);
    queue_item(CMD_PLAIN, 5'd3, 1'b0);
    queue_item(CMD_CIPHER, 5'd15, 1'b0);
    queue_item(CMD_PLAIN, 5'd4, 1'b0);
    queue_item(CMD_CLEAR, 5'd0, 1'b0);
    queue_item(CMD_KEY, 5'd16, 1'b0);
    queue_item(CMD_PLAIN, 5'd1, 1'b0);
    queue_item(CMD_PLAIN, 5'd2, 1'b1);
    while (queued < ITEM_GOAL) queue_phase();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (stim_q.size() != 0 || in_tvalid || letters_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (letters_due.size() != 0) report_mismatch("results never delivered", 0,
                                                 letters_due.size());
    $display("Run covered %0d accepted input transactions over %0d key and message phases,",
             items_taken, phases);
    $display("with %0d result transactions checked and %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Source side: presents queued items, holding each until it is taken.
  always @(negedge clk) begin
    stim_t s;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (stim_q.size() != 0 && (!stim_q[0].drain || letters_due.size() == 0) &&
          (steady || $urandom_range(99) >= 31)) begin
        s = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {3'b000, s.letter};
        in_tuser <= s.cmd;
        in_tlast <= s.msg_end;
        sent_count <= sent_count + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: random backpressure on the result channel.
  always @(negedge clk) begin
    if (rst_n) begin
      out_tready <= steady || $urandom_range(99) >= 31;
    end
  end

  always @(posedge clk) begin
    result_t want;
    stim_t   s;
    if (!rst_n) begin
      in_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        s.cmd = in_tuser;
        s.letter = in_tdata[4:0];
        s.msg_end = in_tlast;
        s.drain = 1'b0;
        playfair_step(s);
        items_taken++;
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (letters_due.size() == 0) begin
          report_mismatch("result transaction with nothing expected", out_tdata[4:0], 0);
        end else begin
          want = letters_due.pop_front();
          if (out_tdata[4:0] !== want.letter)
            report_mismatch("out_letter", out_tdata[4:0], want.letter);
          if (out_tlast !== want.run_end)
            report_mismatch("run_end", out_tlast, want.run_end);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_MAX) begin
        $display("timeout: no transaction for %0d cycles", STALL_MAX);
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
